[rtl/fbf_pkg.sv]
// ----------------------------------------------------------------------------
// Formant filter bank package
// Shared widths, register and step codes, step bundle and saturation helper.
// ----------------------------------------------------------------------------
package fbf_pkg;

   // default parameter values
   localparam int SAMPLE_BITS_DEF    = 24;
   localparam int COEF_FRAC_BITS_DEF = 18;
   localparam int CHANNELS_DEF       = 2;

   // band structure
   localparam int BANDS  = 3;
   localparam int BAND_W = 2;
   localparam logic [BAND_W-1:0] BAND_LAST = BAND_W'(BANDS - 1);

   // register layout
   localparam int COEF_FIELD_W = 20;
   localparam int COEF_REG_W   = 3 * COEF_FIELD_W;
   localparam int GAIN_FIELD_W = 16;
   localparam int GAIN_FRAC_W  = 12;
   localparam int GAIN_REG_W   = BANDS * GAIN_FIELD_W;
   localparam logic [GAIN_REG_W-1:0] GAIN_RESET = 48'h1000_1000_1000;

   // configuration port
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 64;
   localparam logic [CSR_INDEX_W-1:0] REG_BAND_ONE   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_BAND_TWO   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_BAND_THREE = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_GAINS      = 3'd3;

   // datapath widths: delay words Q9.31, split multiplies in two halves
   localparam int WORD_W      = 40;
   localparam int WORD_FRAC_W = 31;
   localparam int HALF_W      = WORD_W / 2;
   localparam int MUL_W       = HALF_W + 1;
   localparam int PART_W      = 2 * MUL_W;
   localparam int PROD_W      = 61;
   localparam int SUM_W       = PROD_W + 1;
   localparam int ACC_W       = WORD_W + GAIN_FIELD_W - GAIN_FRAC_W + 2;

   // operation within one band
   localparam int OP_W = 2;
   localparam logic [OP_W-1:0] OP_B0   = 2'd0;
   localparam logic [OP_W-1:0] OP_A1   = 2'd1;
   localparam logic [OP_W-1:0] OP_A2   = 2'd2;
   localparam logic [OP_W-1:0] OP_GAIN = 2'd3;

   // phase within one operation
   localparam int PH_W = 2;
   localparam logic [PH_W-1:0] PH_LO  = 2'd0;
   localparam logic [PH_W-1:0] PH_HI  = 2'd1;
   localparam logic [PH_W-1:0] PH_SUM = 2'd2;

   // step broadcast from the sequencer to every lane
   typedef struct packed {
      logic              start;
      logic              run;
      logic [BAND_W-1:0] band;
      logic [OP_W-1:0]   op;
      logic [PH_W-1:0]   phase;
   } step_type;

   // clamp a wide sum to the signed delay word range
   function automatic logic signed [WORD_W-1:0] sat_word(input logic signed [SUM_W-1:0] v);
      logic [SUM_W-WORD_W:0] top;
      top = v[SUM_W-1:WORD_W-1];
      if ((&top) || !(|top)) begin
         return v[WORD_W-1:0];
      end
      return {v[SUM_W-1], {(WORD_W-1){~v[SUM_W-1]}}};
   endfunction

endpackage

[rtl/formant_bandpass_filter_bank.sv]
// ----------------------------------------------------------------------------
// Formant band-pass filter bank
// Three band-pass biquads per channel, weighted and summed per frame.
// ----------------------------------------------------------------------------
// Each frame runs, from acceptance to its result being registered, through
// the twelve multiplies of each channel lane (b0, a1, a2 and gain for three
// bands) on one 21 x 21 multiplier, each multiply split into phases for the
// low partial product, the high partial product and their sum, and then the
// output register is loaded. A new frame is taken the cycle after the
// previous result has been loaded, so a frame is not accepted before the last
// one is through; a stalled output holds the finished frame and the input
// until the register frees up. All channels run in parallel lanes. Write
// configuration only while idle.
module formant_bandpass_filter_bank #(
   parameter int SAMPLE_BITS    = fbf_pkg::SAMPLE_BITS_DEF,
   parameter int COEF_FRAC_BITS = fbf_pkg::COEF_FRAC_BITS_DEF,
   parameter int CHANNELS       = fbf_pkg::CHANNELS_DEF,
   parameter int TDATA_W        = ((CHANNELS * SAMPLE_BITS + 7) / 8) * 8
) (
   input  logic                               clock,
   input  logic                               reset,
   // input frame
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [TDATA_W-1:0]                 req_tdata,  // left_in, right_in, ... per channel
   // result frame
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [TDATA_W-1:0]                 rsp_tdata,  // left_out, right_out, ... per channel
   // register writes
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [fbf_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [fbf_pkg::CSR_DATA_W-1:0]     csr_data
);
   import fbf_pkg::*;

   logic [BANDS-1:0][COEF_REG_W-1:0]   coeffs_ff, coeffs_in;
   logic [GAIN_REG_W-1:0]              gains_ff, gains_in;
   step_type                           step;
   logic                               can_load;
   logic                               out_load;
   logic [CHANNELS-1:0][SAMPLE_BITS-1:0] lane_results;

   // register writes, unknown indexes ignored
   assign csr_ready = 1'b1;

   always_comb begin
      coeffs_in = coeffs_ff;
      gains_in  = gains_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_BAND_ONE, REG_BAND_TWO, REG_BAND_THREE: begin
               coeffs_in[csr_index[BAND_W-1:0]] = csr_data[COEF_REG_W-1:0];
            end
            REG_GAINS: begin
               gains_in = csr_data[GAIN_REG_W-1:0];
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coeffs_ff <= '0;
         gains_ff  <= GAIN_RESET;
      end else begin
         coeffs_ff <= coeffs_in;
         gains_ff  <= gains_in;
      end
   end

   fbf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .can_load   (can_load),
      .out_load   (out_load),
      .step       (step)
   );

   // one lane per channel
   for (genvar ch = 0; ch < CHANNELS; ch++) begin : g_lane
      fbf_lane #(
         .SAMPLE_BITS    (SAMPLE_BITS),
         .COEF_FRAC_BITS (COEF_FRAC_BITS)
      ) u_lane (
         .clock  (clock),
         .reset  (reset),
         .step   (step),
         .sample (req_tdata[ch*SAMPLE_BITS +: SAMPLE_BITS]),
         .coeffs (coeffs_ff),
         .gains  (gains_ff),
         .result (lane_results[ch])
      );
   end

   fbf_merge #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .CHANNELS    (CHANNELS),
      .TDATA_W     (TDATA_W)
   ) u_merge (
      .clock        (clock),
      .reset        (reset),
      .load         (out_load),
      .lane_results (lane_results),
      .can_load     (can_load),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata)
   );

endmodule

[rtl/fbf_ctrl.sv]
// ----------------------------------------------------------------------------
// Formant filter bank sequencer
// Walks bands, operations and multiply phases for all lanes in lockstep.
// ----------------------------------------------------------------------------
module fbf_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic              can_load,
   output logic              out_load,
   output fbf_pkg::step_type step
);
   import fbf_pkg::*;

   localparam int ST_W = 2;
   localparam logic [ST_W-1:0] ST_IDLE = 2'd0;
   localparam logic [ST_W-1:0] ST_RUN  = 2'd1;
   localparam logic [ST_W-1:0] ST_DONE = 2'd2;

   logic [ST_W-1:0]   state_ff, state_in;
   logic [BAND_W-1:0] band_ff, band_in;
   logic [OP_W-1:0]   op_ff, op_in;
   logic [PH_W-1:0]   phase_ff, phase_in;

   assign req_tready = (state_ff == ST_IDLE);
   assign out_load   = (state_ff == ST_DONE) && can_load;

   // advance through phase, operation and band
   always_comb begin
      state_in   = state_ff;
      band_in    = band_ff;
      op_in      = op_ff;
      phase_in   = phase_ff;
      step.start = 1'b0;
      step.run   = (state_ff == ST_RUN);
      step.band  = band_ff;
      step.op    = op_ff;
      step.phase = phase_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               step.start = 1'b1;
               state_in   = ST_RUN;
               band_in    = '0;
               op_in      = OP_B0;
               phase_in   = PH_LO;
            end
         end
         ST_RUN: begin
            if (phase_ff == PH_SUM) begin
               phase_in = PH_LO;
               if (op_ff == OP_GAIN) begin
                  op_in = OP_B0;
                  if (band_ff == BAND_LAST) begin
                     state_in = ST_DONE;
                  end else begin
                     band_in = band_ff + 1'b1;
                  end
               end else begin
                  op_in = op_ff + 1'b1;
               end
            end else begin
               phase_in = phase_ff + 1'b1;
            end
         end
         ST_DONE: begin
            if (can_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         band_ff  <= '0;
         op_ff    <= OP_B0;
         phase_ff <= PH_LO;
      end else begin
         state_ff <= state_in;
         band_ff  <= band_in;
         op_ff    <= op_in;
         phase_ff <= phase_in;
      end
   end

   // accepted beat starts a run
   a_accept_runs: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> state_ff == ST_RUN)
      else $error("accepted beat did not start a run");

   // band counter stays within the bank while running
   a_band_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_RUN |-> band_ff <= BAND_LAST)
      else $error("band counter out of range");

   // result is offered only after the last gain step of the last band
   a_done_entry: assert property (@(posedge clock) disable iff (reset)
      $rose(state_ff == ST_DONE) |-> $past(band_ff) == BAND_LAST &&
      $past(op_ff) == OP_GAIN && $past(phase_ff) == PH_SUM)
      else $error("run finished early");

endmodule

[rtl/fbf_lane.sv]
// ----------------------------------------------------------------------------
// Formant filter bank lane
// One channel: three band-pass biquads on a shared split multiplier,
// weighted band sum and output saturation.
// ----------------------------------------------------------------------------
module fbf_lane #(
   parameter int SAMPLE_BITS    = fbf_pkg::SAMPLE_BITS_DEF,
   parameter int COEF_FRAC_BITS = fbf_pkg::COEF_FRAC_BITS_DEF
) (
   input  logic                                                clock,
   input  logic                                                reset,
   input  fbf_pkg::step_type                                   step,
   input  logic [SAMPLE_BITS-1:0]                              sample,
   input  logic [fbf_pkg::BANDS-1:0][fbf_pkg::COEF_REG_W-1:0]  coeffs,
   input  logic [fbf_pkg::GAIN_REG_W-1:0]                      gains,
   output logic [SAMPLE_BITS-1:0]                              result
);
   import fbf_pkg::*;

   localparam int SAMPLE_SHIFT = WORD_FRAC_W + 1 - SAMPLE_BITS;

   logic        [SAMPLE_BITS-1:0] sample_ff, sample_in;
   logic signed [PART_W-1:0]      prod_ff, prod_in;
   logic signed [PART_W-1:0]      lo_ff, lo_in;
   logic signed [PROD_W-1:0]      bx_ff, bx_in;
   logic signed [WORD_W-1:0]      y_ff, y_in;
   logic signed [ACC_W-1:0]       acc_ff, acc_in;
   logic signed [WORD_W-1:0]      s1_ff [BANDS];
   logic signed [WORD_W-1:0]      s1_in [BANDS];
   logic signed [WORD_W-1:0]      s2_ff [BANDS];
   logic signed [WORD_W-1:0]      s2_in [BANDS];

   logic [COEF_REG_W-1:0]      band_coeffs;
   logic [GAIN_FIELD_W-1:0]    gain_field;
   logic signed [MUL_W-1:0]    mul_a;
   logic signed [MUL_W-1:0]    mul_b;
   logic signed [WORD_W-1:0]   x_word;
   logic signed [WORD_W-1:0]   operand;
   logic signed [PART_W-1:0]   mul_res;
   logic signed [PROD_W-1:0]   full;
   logic signed [PROD_W-1:0]   coef_scaled;
   logic signed [PROD_W-1:0]   gain_scaled;
   logic signed [ACC_W-1:0]    shifted;
   logic                       fits;

   // pick coefficient or gain for the current operation
   assign band_coeffs = coeffs[step.band];
   assign gain_field  = gains[step.band*GAIN_FIELD_W +: GAIN_FIELD_W];

   always_comb begin
      unique case (step.op)
         OP_B0:   mul_a = MUL_W'(signed'(band_coeffs[0*COEF_FIELD_W +: COEF_FIELD_W]));
         OP_A1:   mul_a = MUL_W'(signed'(band_coeffs[1*COEF_FIELD_W +: COEF_FIELD_W]));
         OP_A2:   mul_a = MUL_W'(signed'(band_coeffs[2*COEF_FIELD_W +: COEF_FIELD_W]));
         OP_GAIN: mul_a = signed'({{(MUL_W-GAIN_FIELD_W){1'b0}}, gain_field});
         default: mul_a = '0;
      endcase
   end

   // sample moved to Q9.31, then the low or the high half of the word by phase
   assign x_word  = WORD_W'(signed'(sample_ff)) <<< SAMPLE_SHIFT;
   assign operand = (step.op == OP_B0) ? x_word : y_ff;
   assign mul_b   = (step.phase == PH_LO) ?
                    signed'({1'b0, operand[HALF_W-1:0]}) :
                    signed'({operand[WORD_W-1], operand[WORD_W-1:HALF_W]});
   assign mul_res = mul_a * mul_b;

   // recombine the two partial products
   assign full        = PROD_W'(lo_ff) + (PROD_W'(prod_ff) <<< HALF_W);
   assign coef_scaled = full >>> COEF_FRAC_BITS;
   assign gain_scaled = full >>> GAIN_FRAC_W;

   // multiply phases and biquad updates
   always_comb begin
      sample_in = sample_ff;
      prod_in   = prod_ff;
      lo_in     = lo_ff;
      bx_in     = bx_ff;
      y_in      = y_ff;
      acc_in    = acc_ff;
      s1_in     = s1_ff;
      s2_in     = s2_ff;
      if (step.start) begin
         sample_in = sample;
         acc_in    = '0;
      end
      if (step.run) begin
         unique case (step.phase)
            PH_LO: begin
               prod_in = mul_res;
            end
            PH_HI: begin
               lo_in   = prod_ff;
               prod_in = mul_res;
            end
            PH_SUM: begin
               unique case (step.op)
                  OP_B0: begin
                     bx_in = coef_scaled;
                     y_in  = sat_word(SUM_W'(coef_scaled) + SUM_W'(s1_ff[step.band]));
                  end
                  OP_A1: begin
                     s1_in[step.band] = sat_word(SUM_W'(s2_ff[step.band]) -
                                                 SUM_W'(coef_scaled));
                  end
                  OP_A2: begin
                     s2_in[step.band] = sat_word(-SUM_W'(bx_ff) - SUM_W'(coef_scaled));
                  end
                  OP_GAIN: begin
                     acc_in = acc_ff + ACC_W'(gain_scaled);
                  end
                  default: ;
               endcase
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      sample_ff <= sample_in;
      prod_ff   <= prod_in;
      lo_ff     <= lo_in;
      bx_ff     <= bx_in;
      y_ff      <= y_in;
      acc_ff    <= acc_in;
   end

   // delay words clear at reset
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int b = 0; b < BANDS; b++) begin
            s1_ff[b] <= '0;
            s2_ff[b] <= '0;
         end
      end else begin
         s1_ff <= s1_in;
         s2_ff <= s2_in;
      end
   end

   // scale the band sum back to the sample and clamp
   assign shifted = acc_ff >>> SAMPLE_SHIFT;
   assign fits    = (&shifted[ACC_W-1:SAMPLE_BITS-1]) || !(|shifted[ACC_W-1:SAMPLE_BITS-1]);
   assign result  = fits ? shifted[SAMPLE_BITS-1:0] :
                    {shifted[ACC_W-1], {(SAMPLE_BITS-1){~shifted[ACC_W-1]}}};

endmodule

[rtl/fbf_merge.sv]
// ----------------------------------------------------------------------------
// Formant filter bank merge stage
// Collects the lane results into one output beat and holds it until taken.
// ----------------------------------------------------------------------------
module fbf_merge #(
   parameter int SAMPLE_BITS = fbf_pkg::SAMPLE_BITS_DEF,
   parameter int CHANNELS    = fbf_pkg::CHANNELS_DEF,
   parameter int TDATA_W     = ((CHANNELS * SAMPLE_BITS + 7) / 8) * 8
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  load,
   input  logic [CHANNELS-1:0][SAMPLE_BITS-1:0]  lane_results,
   output logic                                  can_load,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [TDATA_W-1:0]                    rsp_tdata
);
   import fbf_pkg::*;

   logic                                 valid_ff, valid_in;
   logic [CHANNELS*SAMPLE_BITS-1:0]      data_ff, data_in;

   // room when empty or the held beat leaves now
   assign can_load = !valid_ff || rsp_tready;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (rsp_tready) begin
         valid_in = 1'b0;
      end
      if (load) begin
         valid_in = 1'b1;
         data_in  = lane_results;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = TDATA_W'(data_ff);

endmodule
